// File: rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants
// Control word that travels with each beat through the square-root pipeline.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int WHOLE_BITS = 8;
  localparam int DEC_BITS   = 14;
  localparam logic [DEC_BITS-1:0] DEC_SCALE = 14'd10000;

  typedef struct packed {
    logic valid;
    logic invalid;
    logic zero;
  } ctl_t;

endpackage

// File: rtl/nsr_in_if.sv
// ----------------------------------------------------------------------------
// nsr_in_if / nsr_out_if: operand and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface nsr_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] operand;
  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

interface nsr_out_if;
  logic        valid;
  logic        ready;
  logic        invalid;
  logic [7:0]  whole_part;
  logic [13:0] decimal_fraction;
  modport source (output valid, output invalid, output whole_part,
                  output decimal_fraction, input ready);
  modport sink   (input valid, input invalid, input whole_part,
                  input decimal_fraction, output ready);
endinterface

// File: rtl/nsr_iter.sv
// ----------------------------------------------------------------------------
// nsr_iter: one Newton-Raphson iteration
// One restoring-division bit per stage, then a stage for (g + q) / 2.
// ----------------------------------------------------------------------------
module nsr_iter
  import nsr_pkg::*;
#(
  parameter int XW = 15,
  parameter int F  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ctl_t                  ctl_in,
  input  logic [XW-1:0]         x_in,
  input  logic [XW+2*F-1:0]     g_in,
  output ctl_t                  ctl_out,
  output logic [XW-1:0]         x_out,
  output logic [XW+2*F-1:0]     g_out
);
  localparam int N = XW + 2*F;

  ctl_t          ctl_s [0:N];
  logic [XW-1:0] x_s   [0:N];
  logic [N-1:0]  g_s   [0:N];
  logic [N-1:0]  r_s   [0:N];
  logic [N-1:0]  q_s   [0:N];

  assign ctl_s[0] = ctl_in;
  assign x_s[0]   = x_in;
  assign g_s[0]   = g_in;
  assign r_s[0]   = '0;
  assign q_s[0]   = '0;

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam int I = N - 1 - s;
    logic         dbit;
    logic [N:0]   r_sh;
    logic         ge;
    if (I >= 2*F) begin : g_xbit
      assign dbit = x_s[s][I-2*F];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end
    assign r_sh = {r_s[s], dbit};
    assign ge   = r_sh >= {1'b0, g_s[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[s+1].valid <= 1'b0;
      end else if (en) begin
        ctl_s[s+1].valid <= ctl_s[s].valid;
      end
      if (en) begin
        ctl_s[s+1].invalid <= ctl_s[s].invalid;
        ctl_s[s+1].zero    <= ctl_s[s].zero;
        x_s[s+1] <= x_s[s];
        g_s[s+1] <= g_s[s];
        r_s[s+1] <= ge ? N'(r_sh - {1'b0, g_s[s]}) : N'(r_sh);
        q_s[s+1] <= {q_s[s][N-2:0], ge};
      end
    end
  end

  logic [N:0] sum;
  assign sum = {1'b0, g_s[N]} + {1'b0, q_s[N]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_s[N].valid;
    end
    if (en) begin
      ctl_out.invalid <= ctl_s[N].invalid;
      ctl_out.zero    <= ctl_s[N].zero;
      x_out <= x_s[N];
      g_out <= sum[N:1];
    end
  end
endmodule

// File: rtl/nsr_round.sv
// ----------------------------------------------------------------------------
// nsr_round: decimal rounding and result register
// Scale the fraction by 10000 with round-half-up, then split into fields.
// ----------------------------------------------------------------------------
module nsr_round
  import nsr_pkg::*;
#(
  parameter int N = 47,
  parameter int F = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ctl_t          ctl_in,
  input  logic [N-1:0]  g_in,
  output ctl_t          ctl_out,
  output logic [WHOLE_BITS-1:0] whole,
  output logic [DEC_BITS-1:0]   dec
);
  localparam int PW = F + DEC_BITS + 1;

  ctl_t                  ctl_a;
  logic [WHOLE_BITS-1:0] ip_a;
  logic [PW-1:0]         prod_a;
  logic [DEC_BITS-1:0]   t;
  logic                  carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else if (en) begin
      ctl_a.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_a.invalid <= ctl_in.invalid;
      ctl_a.zero    <= ctl_in.zero;
      ip_a   <= g_in[F+WHOLE_BITS-1:F];
      prod_a <= PW'(g_in[F-1:0]) * PW'(DEC_SCALE) + (PW'(1) << (F-1));
    end
  end

  // rounded fraction never exceeds 10000; at exactly 10000 carry into whole
  assign t     = prod_a[F+DEC_BITS-1:F];
  assign carry = t == DEC_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_a.valid;
    end
    if (en) begin
      ctl_out.invalid <= ctl_a.invalid;
      ctl_out.zero    <= ctl_a.zero;
      if (ctl_a.invalid || ctl_a.zero) begin
        whole <= '0;
        dec   <= '0;
      end else begin
        whole <= ip_a + WHOLE_BITS'(carry);
        dec   <= carry ? '0 : t;
      end
    end
  end
endmodule

// File: rtl/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root: pipelined fixed-point Newton-Raphson square root
// Signed operand in, root rounded to four decimal places out.
// ----------------------------------------------------------------------------
// Each operand beat is turned into unsigned fixed point with FRAC_BITS
// fraction bits, seeded with x/2, and run through ITERATIONS unrolled
// Newton-Raphson updates g = (g + X/g) / 2 with truncating division. Every
// division is a restoring divider of one quotient bit per register stage, and
// each iteration ends in a register stage for the halving. An entry stage
// classifies and seeds each operand ahead of the iterations, and the rounding
// stages follow them. A new beat is accepted every cycle unless the pipeline
// is held: the whole pipeline holds while the result register waits
// on rsp.ready. A negative operand returns invalid with zero fields; zero
// returns all zeros.
// ----------------------------------------------------------------------------
module newton_square_root
  import nsr_pkg::*;
#(
  parameter int INPUT_BITS = 16,
  parameter int ITERATIONS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  nsr_in_if.sink    req,
  nsr_out_if.source rsp
);
  localparam int XW = INPUT_BITS - 1;
  localparam int N  = XW + 2*FRAC_BITS;

  // advance everything when the result register is empty or being drained
  logic en;
  ctl_t ctl_o;
  assign en        = !ctl_o.valid || rsp.ready;
  assign req.ready = en;

  ctl_t          ctl_c [0:ITERATIONS];
  logic [XW-1:0] x_c   [0:ITERATIONS];
  logic [N-1:0]  g_c   [0:ITERATIONS];

  // entry stage: classify the operand and seed the guess at X/2
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0].valid <= 1'b0;
    end else if (en) begin
      ctl_c[0].valid <= req.valid;
    end
    if (en) begin
      ctl_c[0].invalid <= req.operand[INPUT_BITS-1];
      ctl_c[0].zero    <= req.operand == '0;
      x_c[0] <= req.operand[XW-1:0];
      g_c[0] <= N'({req.operand[XW-1:0], FRAC_BITS'(0)} >> 1);
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    nsr_iter #(.XW(XW), .F(FRAC_BITS)) u_iter (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_c[k]),
      .x_in    (x_c[k]),
      .g_in    (g_c[k]),
      .ctl_out (ctl_c[k+1]),
      .x_out   (x_c[k+1]),
      .g_out   (g_c[k+1])
    );
  end

  nsr_round #(.N(N), .F(FRAC_BITS)) u_round (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_c[ITERATIONS]),
    .g_in    (g_c[ITERATIONS]),
    .ctl_out (ctl_o),
    .whole   (rsp.whole_part),
    .dec     (rsp.decimal_fraction)
  );

  assign rsp.valid   = ctl_o.valid;
  assign rsp.invalid = ctl_o.invalid;

  // an invalid result carries zero fields
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.invalid |-> rsp.whole_part == '0 && rsp.decimal_fraction == '0)
    else $error("invalid result with nonzero fields");

  // fraction digits stay below 10000
  a_dec_range : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.decimal_fraction < DEC_SCALE)
    else $error("decimal fraction out of range");

  // input is held back only by a stalled result
  a_stall_src : assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("input stalled without output backpressure");

  // a stalled result keeps its flag
  a_hold : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.invalid))
    else $error("stalled result changed");
endmodule

// File: tb/sv/newton_square_root_tb.sv
// ----------------------------------------------------------------------------
// newton_square_root_tb: self-checking bench for the square-root pipeline
// Drives signed operands over the request channel, predicts each rounded
// root with a bit-accurate fixed-point Newton-Raphson model and compares
// every response beat in order. Both channels idle at random, and one long
// response stall holds the pipeline.
// ----------------------------------------------------------------------------
module newton_square_root_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsr_pkg::*;

  localparam int  IN_BITS   = 16;
  localparam int  ITERS     = 10;
  localparam int  FBITS     = 16;
  localparam int  LATENCY   = 1 + ITERS * (IN_BITS + 2 * FBITS) + 2;
  localparam longint LIMIT  = 2_000_000;

  typedef struct packed {
    logic                  invalid;
    logic [WHOLE_BITS-1:0] whole_part;
    logic [DEC_BITS-1:0]   decimal_fraction;
  } root_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nsr_in_if #(.W(IN_BITS)) req ();
  nsr_out_if               rsp ();

  newton_square_root #(
    .INPUT_BITS (IN_BITS),
    .ITERATIONS (ITERS),
    .FRAC_BITS  (FBITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // 20 ns period: high then low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  root_t  pending_roots[$];
  int     errors      = 0;
  int     beats_sent  = 0;
  int     beats_seen  = 0;
  int     neg_count   = 0;
  longint cycle_count = 0;
  int     stall_hold  = 0;     // long hold-off requested from the sender side
  bit     rsp_idle_on = 1'b1;  // random response stalls enabled

  // Restoring division of (x << 2*FBITS) by d, one quotient bit per step.
  function automatic logic [63:0] scaled_quotient(logic [63:0] x, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    logic        nb;
    rem = '0;
    quo = '0;
    if (d == 0) return '1;
    for (int i = IN_BITS - 2 + 2 * FBITS; i >= 0; i--) begin
      nb  = (i >= 2 * FBITS) ? x[i - 2 * FBITS] : 1'b0;
      rem = {rem[62:0], nb};
      if (rem >= d) begin
        rem = rem - d;
        quo = {quo[62:0], 1'b1};
      end else begin
        quo = {quo[62:0], 1'b0};
      end
    end
    return quo;
  endfunction

  function automatic root_t predict_root(logic [IN_BITS-1:0] operand);
    root_t       r;
    logic [63:0] x;
    logic [63:0] guess;
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] total;
    r = '0;
    x = 64'(operand);
    if (operand[IN_BITS-1]) begin
      r.invalid = 1'b1;
      return r;
    end
    if (operand == 0) return r;
    guess = (x << FBITS) >> 1;
    for (int k = 0; k < ITERS; k++)
      guess = (guess + scaled_quotient(x, guess)) >> 1;
    ipart = guess >> FBITS;
    fpart = guess & ((64'd1 << FBITS) - 1);
    total = ipart * 10000 + ((fpart * 10000 + (64'd1 << (FBITS - 1))) >> FBITS);
    r.whole_part       = WHOLE_BITS'(total / 10000);
    r.decimal_fraction = DEC_BITS'(total % 10000);
    return r;
  endfunction

  // Short gaps and no gap at all in about equal shares, and a few long ones.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one operand, after an optional random gap, and hold it until the beat is taken.
  task automatic send_operand(logic [IN_BITS-1:0] operand, bit with_gap = 1'b1);
    int gap;
    gap = with_gap ? gap_length() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.operand <= operand;
    pending_roots.push_back(predict_root(operand));
    beats_sent++;
    if (operand[IN_BITS-1]) neg_count++;
    do @(posedge clk); while (!req.ready);
  endtask

  // Drop valid and wait on the clock, leaving the request channel idle.
  task automatic drop_valid();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drive random response stalls, or a long fixed hold when one is requested.
  initial begin : rsp_ready_driver
    int gap;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        // Hold off in its own loop, counted in cycles.
        rsp.ready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
        rsp.ready <= 1'b1;
      end else if (rsp_idle_on) begin
        gap = gap_length();
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end else begin
          rsp.ready <= 1'b1;
        end
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Compare each response beat with the oldest predicted root.
  always @(posedge clk) begin
    root_t want;
    root_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.invalid, rsp.whole_part, rsp.decimal_fraction};
      beats_seen++;
      if (pending_roots.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0d] unexpected result beat inv=%0b whole=%0d frac=%0d",
                   cycle_count, got.invalid, got.whole_part, got.decimal_fraction);
      end else begin
        want = pending_roots.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"[%0d] mismatch: want inv=%0b whole=%0d frac=%0d,",
                      " got inv=%0b whole=%0d frac=%0d"},
                     cycle_count, want.invalid, want.whole_part, want.decimal_fraction,
                     got.invalid, got.whole_part, got.decimal_fraction);
        end
      end
    end
  end

  // Guard the run against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Field extremes, zero, perfect squares, the largest operands and negative ones.
  task automatic test_directed();
    logic [IN_BITS-1:0] corner[$];
    corner = '{16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd9, 16'sd10, 16'sd99,
               16'sd100, 16'sd255, 16'sd256, 16'sd1000, 16'sd16384, 16'sd32760,
               16'sd32761, 16'sd32767, -16'sd1, -16'sd2, 16'h8000,
               -16'sd32767, 16'h5555, 16'h2AAA, 16'hAAAA};
    foreach (corner[i]) send_operand(corner[i]);
    drop_valid();
  endtask

  // Random operands: mostly positive, spread over every bit width.
  task automatic test_random(int count);
    logic [IN_BITS-1:0] op;
    int                 sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(9);
      if (sel < 2)       op = IN_BITS'($urandom);                  // any sign
      else if (sel < 4)  op = IN_BITS'($urandom_range(0, 300));    // small roots
      else               op = {1'b0, 15'($urandom) >> $urandom_range(0, 14)};
      send_operand(op);
    end
    drop_valid();
  endtask

  // Stall the response for a long stretch while operands are offered back to back.
  task automatic test_backpressure(int count);
    stall_hold = 2 * LATENCY;
    for (int n = 0; n < count; n++)
      send_operand({1'b0, 15'($urandom)}, 1'b0);
    drop_valid();
  endtask

  // Back-to-back operands into a sink that never stalls.
  task automatic test_streaming(int count);
    rsp_idle_on = 1'b0;
    for (int n = 0; n < count; n++)
      send_operand(IN_BITS'($urandom), 1'b0);
    drop_valid();
    rsp_idle_on = 1'b1;
  endtask

  initial begin
    req.valid   <= 1'b0;
    req.operand <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150);
    test_backpressure(520);
    test_streaming(60);
    test_random(50);

    // Drain, then keep clocking so that any stray beats show up.
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Covered %0d operands (%0d negative), %0d results checked,", beats_sent,
             neg_count, beats_seen);
    $display("including one long response stall that filled the pipeline.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
